/* design/message_ring_queue_core_defines.svh */
// assertion macros used by the checker file
`ifndef MESSAGE_RING_QUEUE_CORE_DEFINES_SVH
`define MESSAGE_RING_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MRQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/mrq_pkg.sv */
// shared types, codes and defaults of the message ring queue
package mrq_pkg;

	localparam int DEF_QUEUE_DEPTH   = 8;
	localparam int DEF_MAX_MSG_BYTES = 16;

	localparam int OUT_LEN_W = 5;

	localparam logic [1:0] KIND_HDR  = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_RX   = 2'd2;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_LEN = 3'd1,
		ST_FULL    = 3'd2,
		ST_SMALL   = 3'd3,
		ST_EMPTY   = 3'd4,
		ST_SEQ     = 3'd5
	} status_t;

	// what the output register is loaded with
	typedef enum logic [1:0] {
		RES_STATUS = 2'd0,
		RES_CHECK  = 2'd1,
		RES_BYTE   = 2'd2,
		RES_NOBYTE = 2'd3
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_RD   = 2'd2,
		S_OUT  = 2'd3
	} state_t;

	typedef struct packed {
		logic    load;
		logic    emit;
		res_t    res;
		status_t code;
		logic    hdr_write;
		logic    data_write;
		logic    rx_start;
		logic    rx_step;
		logic    rx_done;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       want;
		logic       open;
		logic       len_bad;
		logic       wr_full;
		logic       rd_full;
		logic       too_small;
		logic       rx_len_zero;
		logic       rx_last;
		logic       out_free;
	} stat_t;

endpackage

/* design/message_ring_queue_core.sv */
// message ring queue: top level joining controller and datapath
// a taken word is latched; the execute state then loads a single-word result into the output
// register, while a receive loads its bytes from the output state after the read state; a
// stalled output register holds both back. every word passes the idle and execute states; a
// receive loops over read and output, one byte per registered payload memory read
// reset: flags, indices, open message and output valid clear at once; stores need no pass
module message_ring_queue_core #(
	parameter int QUEUE_DEPTH   = mrq_pkg::DEF_QUEUE_DEPTH,
	parameter int MAX_MSG_BYTES = mrq_pkg::DEF_MAX_MSG_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request word
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic                          want_receive,
	input  logic [7:0]                    msg_length,
	input  logic [7:0]                    msg_type,
	input  logic [7:0]                    data_byte,
	input  logic [7:0]                    max_length,
	// result word
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [7:0]                    out_type,
	output logic [mrq_pkg::OUT_LEN_W-1:0] out_length,
	output logic [7:0]                    out_byte,
	output logic                          byte_valid,
	output logic                          last,
	output logic                          available
);
	import mrq_pkg::*;

	// commands from the state machine, status back from the datapath
	cmd_t  cmd;
	stat_t stat;

	// controller: one request word at a time; a receive loops over read and output steps
	mrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: slot flags and stores, ring indices, payload memory, output register
	mrq_dpath #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.MAX_MSG_BYTES (MAX_MSG_BYTES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.want_receive (want_receive),
		.msg_length   (msg_length),
		.msg_type     (msg_type),
		.data_byte    (data_byte),
		.max_length   (max_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_type     (out_type),
		.out_length   (out_length),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last         (last),
		.available    (available)
	);

endmodule

/* design/mrq_ctrl.sv */
// sequencing state machine of the message ring queue
module mrq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mrq_pkg::stat_t stat,
	output mrq_pkg::cmd_t  cmd
);
	import mrq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.res   = RES_STATUS;
		cmd.code  = ST_OK;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
					cmd.emit  = 1'b1;
					case (stat.kind)
						KIND_HDR: begin
							if (stat.open) begin
								cmd.code = ST_SEQ;
							end else if (stat.len_bad) begin
								cmd.code = ST_BAD_LEN;
							end else if (stat.wr_full) begin
								cmd.code = ST_FULL;
							end else begin
								cmd.hdr_write = 1'b1;
							end
						end
						KIND_DATA: begin
							if (!stat.open) begin
								cmd.code = ST_SEQ;
							end else begin
								cmd.data_write = 1'b1;
							end
						end
						KIND_RX: begin
							if (!stat.want) begin
								cmd.res = RES_CHECK;
							end else if (!stat.rd_full) begin
								cmd.code = ST_EMPTY;
							end else if (stat.too_small) begin
								cmd.code = ST_SMALL;
							end else if (stat.rx_len_zero) begin
								cmd.res     = RES_NOBYTE;
								cmd.rx_done = 1'b1;
							end else begin
								cmd.emit     = 1'b0;
								cmd.rx_start = 1'b1;
								state_nxt    = S_RD;
							end
						end
						default: begin
							cmd.code = ST_SEQ;
						end
					endcase
				end
			end
			S_RD: begin
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.res  = RES_BYTE;
					if (stat.rx_last) begin
						cmd.rx_done = 1'b1;
						state_nxt   = S_IDLE;
					end else begin
						cmd.rx_step = 1'b1;
						state_nxt   = S_RD;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

/* design/mrq_dpath.sv */
// slot stores, indices, payload memory and output register
module mrq_dpath #(
	parameter int QUEUE_DEPTH   = mrq_pkg::DEF_QUEUE_DEPTH,
	parameter int MAX_MSG_BYTES = mrq_pkg::DEF_MAX_MSG_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mrq_pkg::cmd_t                cmd,
	output mrq_pkg::stat_t               stat,
	input  logic [1:0]                   kind,
	input  logic                         want_receive,
	input  logic [7:0]                   msg_length,
	input  logic [7:0]                   msg_type,
	input  logic [7:0]                   data_byte,
	input  logic [7:0]                   max_length,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   status,
	output logic [7:0]                   out_type,
	output logic [mrq_pkg::OUT_LEN_W-1:0] out_length,
	output logic [7:0]                   out_byte,
	output logic                         byte_valid,
	output logic                         last,
	output logic                         available
);
	import mrq_pkg::*;

	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int LEN_W  = $clog2(MAX_MSG_BYTES + 1);
	localparam int PAY_N  = QUEUE_DEPTH * MAX_MSG_BYTES;
	localparam int ADDR_W = (PAY_N > 1) ? $clog2(PAY_N) : 1;

	// latched input word
	logic [1:0] kind_q;
	logic       want_q;
	logic [7:0] len_in_q;
	logic [7:0] type_in_q;
	logic [7:0] byte_in_q;
	logic [7:0] maxlen_q;

	// queue state
	logic [QUEUE_DEPTH-1:0] slot_full_q;
	logic [IDX_W-1:0]       wr_idx_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic                   open_q;
	logic [LEN_W-1:0]       pos_q;
	logic [LEN_W-1:0]       open_len_q;
	logic [LEN_W-1:0]       rx_i_q;

	// slot stores
	logic [7:0]       type_mem_q [QUEUE_DEPTH];
	logic [LEN_W-1:0] len_mem_q  [QUEUE_DEPTH];
	logic [7:0]       pay_mem_q  [PAY_N];
	logic [7:0]       meta_type_q;
	logic [LEN_W-1:0] meta_len_q;
	logic [7:0]       pay_rd_q;

	// output register
	logic                 out_valid_q;
	status_t              status_q;
	logic [7:0]           out_type_q;
	logic [OUT_LEN_W-1:0] out_length_q;
	logic [7:0]           out_byte_q;
	logic                 byte_valid_q;
	logic                 last_q;
	logic                 available_q;

	logic [IDX_W-1:0]  wr_idx_nxt;
	logic [IDX_W-1:0]  rd_idx_nxt;
	logic [LEN_W-1:0]  pos_nxt;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              rx_last;

	assign wr_idx_nxt = (int'(wr_idx_q) == QUEUE_DEPTH - 1) ? '0 : wr_idx_q + IDX_W'(1);
	assign rd_idx_nxt = (int'(rd_idx_q) == QUEUE_DEPTH - 1) ? '0 : rd_idx_q + IDX_W'(1);
	assign pos_nxt    = pos_q + LEN_W'(1);
	assign wr_addr    = ADDR_W'(int'(wr_idx_q) * MAX_MSG_BYTES + int'(pos_q));
	assign rd_addr    = ADDR_W'(int'(rd_idx_q) * MAX_MSG_BYTES + int'(rx_i_q));
	assign rx_last    = (int'(rx_i_q) + 1) == int'(meta_len_q);

	always_comb begin
		stat.kind        = kind_q;
		stat.want        = want_q;
		stat.open        = open_q;
		stat.len_bad     = int'(len_in_q) > MAX_MSG_BYTES;
		stat.wr_full     = slot_full_q[wr_idx_q];
		stat.rd_full     = slot_full_q[rd_idx_q];
		stat.too_small   = int'(meta_len_q) > int'(maxlen_q);
		stat.rx_len_zero = (meta_len_q == '0);
		stat.rx_last     = rx_last;
		stat.out_free    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind;
			want_q    <= want_receive;
			len_in_q  <= msg_length;
			type_in_q <= msg_type;
			byte_in_q <= data_byte;
			maxlen_q  <= max_length;
		end
	end

	// stores: written at the write slot, read continuously at the read slot
	always_ff @(posedge clk) begin
		if (cmd.hdr_write) begin
			type_mem_q[wr_idx_q] <= type_in_q;
			len_mem_q[wr_idx_q]  <= LEN_W'(len_in_q);
		end
		if (cmd.data_write) begin
			pay_mem_q[wr_addr] <= byte_in_q;
		end
		meta_type_q <= type_mem_q[rd_idx_q];
		meta_len_q  <= len_mem_q[rd_idx_q];
		pay_rd_q    <= pay_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.hdr_write) begin
			pos_q      <= '0;
			open_len_q <= LEN_W'(len_in_q);
		end else if (cmd.data_write) begin
			pos_q <= pos_nxt;
		end
		if (cmd.rx_start) begin
			rx_i_q <= '0;
		end else if (cmd.rx_step) begin
			rx_i_q <= rx_i_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_full_q <= '0;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			open_q      <= 1'b0;
		end else begin
			if (cmd.hdr_write) begin
				if (len_in_q == '0) begin
					slot_full_q[wr_idx_q] <= 1'b1;
					wr_idx_q              <= wr_idx_nxt;
				end else begin
					open_q <= 1'b1;
				end
			end
			if (cmd.data_write && (pos_nxt == open_len_q)) begin
				slot_full_q[wr_idx_q] <= 1'b1;
				wr_idx_q              <= wr_idx_nxt;
				open_q                <= 1'b0;
			end
			if (cmd.rx_done) begin
				slot_full_q[rd_idx_q] <= 1'b0;
				rd_idx_q              <= rd_idx_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.res)
				RES_CHECK: begin
					status_q     <= ST_OK;
					out_type_q   <= '0;
					out_length_q <= '0;
					out_byte_q   <= '0;
					byte_valid_q <= 1'b0;
					last_q       <= 1'b1;
					available_q  <= slot_full_q[rd_idx_q];
				end
				RES_NOBYTE: begin
					status_q     <= ST_OK;
					out_type_q   <= meta_type_q;
					out_length_q <= '0;
					out_byte_q   <= '0;
					byte_valid_q <= 1'b0;
					last_q       <= 1'b1;
					available_q  <= 1'b0;
				end
				RES_BYTE: begin
					status_q     <= ST_OK;
					out_type_q   <= meta_type_q;
					out_length_q <= OUT_LEN_W'(meta_len_q);
					out_byte_q   <= pay_rd_q;
					byte_valid_q <= 1'b1;
					last_q       <= rx_last;
					available_q  <= 1'b0;
				end
				default: begin
					status_q     <= cmd.code;
					out_type_q   <= '0;
					out_length_q <= '0;
					out_byte_q   <= '0;
					byte_valid_q <= 1'b0;
					last_q       <= 1'b1;
					available_q  <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_type   = out_type_q;
	assign out_length = out_length_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign last       = last_q;
	assign available  = available_q;

endmodule

/* design/mrq_checker.sv */
// port-level checker for the message ring queue and its bind
`include "message_ring_queue_core_defines.svh"

module mrq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       last,
	input logic       available
);
	import mrq_pkg::*;

	`MRQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(out_byte) && $stable(last), "stalled result word changed")
	`MRQ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while previous one in work")
	`MRQ_ASSERT_SAME(a_single_is_last, out_valid && !byte_valid, last, "word without payload byte not last")
	`MRQ_ASSERT_SAME(a_byte_ok, out_valid && (byte_valid || available), status == ST_OK && !(byte_valid && available), "payload or availability with bad status")

endmodule

bind message_ring_queue_core mrq_checker u_mrq_checker (.*);

/* tb/sv/tb.sv */
// testbench for message_ring_queue_core: directed and random traffic against a built-in predictor
`timescale 1ns / 100ps

module tb;
	import mrq_pkg::*;

	localparam int QD             = DEF_QUEUE_DEPTH;
	localparam int MB             = DEF_MAX_MSG_BYTES;
	localparam int SIZE_W         = OUT_LEN_W;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_LEN   = 300;
	localparam int DRAIN_CYCLES   = 20;

	// kind code that the block has no operation for
	localparam logic [1:0] KIND_BAD = 2'd3;

	// one request word as driven on the input ports
	typedef struct packed {
		logic [1:0] kind;
		logic       want;
		logic [7:0] len;
		logic [7:0] tag;
		logic [7:0] data;
		logic [7:0] limit;
	} mrq_req_t;

	localparam int REQ_W = $bits(mrq_req_t);

	// one result word as seen on the output ports
	typedef struct packed {
		status_t           code;
		logic [7:0]        tag;
		logic [SIZE_W-1:0] msg_size;
		logic [7:0]        payload;
		logic              payload_ok;
		logic              is_last;
		logic              avail;
	} mrq_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        kind = '0;
	logic              want_receive = 1'b0;
	logic [7:0]        msg_length = '0;
	logic [7:0]        msg_type = '0;
	logic [7:0]        data_byte = '0;
	logic [7:0]        max_length = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        status;
	logic [7:0]        out_type;
	logic [SIZE_W-1:0] out_length;
	logic [7:0]        out_byte;
	logic              byte_valid;
	logic              last;
	logic              available;

	message_ring_queue_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.want_receive (want_receive),
		.msg_length   (msg_length),
		.msg_type     (msg_type),
		.data_byte    (data_byte),
		.max_length   (max_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_type     (out_type),
		.out_length   (out_length),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last         (last),
		.available    (available)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// --- predictor state: a private copy of the ring ---
	bit                slot_full [QD];
	logic [7:0]        slot_tag  [QD];
	logic [SIZE_W-1:0] slot_size [QD];
	logic [7:0]        msg_store [QD*MB];
	int                wr_ptr;
	int                rd_ptr;
	int                bytes_left;
	bit                msg_open;

	// result words still owed by the block, oldest first
	mrq_word_t due_words[$];

	int failures;
	int words_sent;
	int quiet_cycles;
	int src_idle_pct;
	int sink_stall_pct;
	int hold_off_cycles;

	function automatic void ring_reset();
		for (int i = 0; i < QD; i++) begin
			slot_full[i] = 1'b0;
		end
		wr_ptr     = 0;
		rd_ptr     = 0;
		bytes_left = 0;
		msg_open   = 1'b0;
	endfunction

	// the write slot is complete: mark it and move on
	function automatic void close_write_slot();
		slot_full[wr_ptr] = 1'b1;
		wr_ptr            = (wr_ptr + 1) % QD;
		msg_open          = 1'b0;
		bytes_left        = 0;
	endfunction

	// apply one accepted word to the ring and queue the result words it causes
	function automatic void ring_step(input mrq_req_t w);
		mrq_word_t r;
		int        n;
		bit        streamed;
		r         = '0;
		r.code    = ST_OK;
		r.is_last = 1'b1;
		streamed  = 1'b0;
		case (w.kind)
			KIND_HDR: begin
				if (msg_open)
					r.code = ST_SEQ;
				else if (w.len > MB)
					r.code = ST_BAD_LEN;
				else if (slot_full[wr_ptr])
					r.code = ST_FULL;
				else begin
					slot_tag[wr_ptr]  = w.tag;
					slot_size[wr_ptr] = SIZE_W'(w.len);
					if (w.len == 0)
						close_write_slot();
					else begin
						msg_open   = 1'b1;
						bytes_left = w.len;
					end
				end
			end
			KIND_DATA: begin
				if (!msg_open || bytes_left == 0 || bytes_left > slot_size[wr_ptr])
					r.code = ST_SEQ;
				else begin
					msg_store[wr_ptr*MB + (int'(slot_size[wr_ptr]) - bytes_left)] = w.data;
					bytes_left--;
					if (bytes_left == 0)
						close_write_slot();
				end
			end
			KIND_RX: begin
				if (!w.want)
					r.avail = slot_full[rd_ptr];
				else if (!slot_full[rd_ptr])
					r.code = ST_EMPTY;
				else begin
					n = slot_size[rd_ptr];
					if (n > MB)
						n = MB;
					if (n > w.limit)
						r.code = ST_SMALL;
					else begin
						r.tag = slot_tag[rd_ptr];
						if (n > 0) begin
							// one word per payload byte, last flag on the final one
							streamed = 1'b1;
							for (int i = 0; i < n; i++) begin
								r.msg_size   = SIZE_W'(n);
								r.payload    = msg_store[rd_ptr*MB + i];
								r.payload_ok = 1'b1;
								r.is_last    = (i == n - 1);
								due_words.push_back(r);
							end
						end
						slot_full[rd_ptr] = 1'b0;
						rd_ptr            = (rd_ptr + 1) % QD;
					end
				end
			end
			default: r.code = ST_SEQ;
		endcase
		if (!streamed)
			due_words.push_back(r);
	endfunction

	// --- result side ---

	// receiver: long hold-off when asked, else random stalls
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_ready <= 1'b0;
			hold_off_cycles--;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			failures++;
		end
	endtask

	// compare every accepted result word with the oldest one owed
	always @(posedge clk) begin : result_check
		mrq_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (due_words.size() == 0) begin
				$error("result word with none owed: status %0d, out_byte %0d", status, out_byte);
				failures++;
			end else begin
				exp_w = due_words.pop_front();
				check_field("status", exp_w.code, status);
				check_field("out_type", exp_w.tag, out_type);
				check_field("out_length", exp_w.msg_size, out_length);
				check_field("out_byte", exp_w.payload, out_byte);
				check_field("byte_valid", exp_w.payload_ok, byte_valid);
				check_field("last", exp_w.is_last, last);
				check_field("available", exp_w.avail, available);
			end
		end
	end

	// watchdog: too long without any word moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** message_ring_queue_core: FAILED **");
			$finish;
		end
	end

	// --- request side ---

	// offer one word, with a random gap first, and wait for it to be taken
	task automatic send_word(input mrq_req_t w);
		int gap;
		gap = 0;
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct && gap < 16)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind         <= w.kind;
		want_receive <= w.want;
		msg_length   <= w.len;
		msg_type     <= w.tag;
		data_byte    <= w.data;
		max_length   <= w.limit;
		in_valid     <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		ring_step(w);
		words_sent++;
	endtask

	// drop valid and wait until every owed word has come out
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// all fields random, so unused ones toggle too
	function automatic mrq_req_t rand_word(input logic [1:0] k);
		mrq_req_t w;
		w      = mrq_req_t'(REQ_W'({$urandom, $urandom}));
		w.kind = k;
		return w;
	endfunction

	function automatic mrq_req_t header_word(input int len, input logic [7:0] tag);
		mrq_req_t w;
		w     = rand_word(KIND_HDR);
		w.len = 8'(len);
		w.tag = tag;
		return w;
	endfunction

	function automatic mrq_req_t data_word(input logic [7:0] b);
		mrq_req_t w;
		w      = rand_word(KIND_DATA);
		w.data = b;
		return w;
	endfunction

	function automatic mrq_req_t rx_word(input logic want, input logic [7:0] limit);
		mrq_req_t w;
		w       = rand_word(KIND_RX);
		w.want  = want;
		w.limit = limit;
		return w;
	endfunction

	// mostly short messages, now and then the longest one
	function automatic int pick_len();
		int p;
		p = $urandom_range(9);
		if (p < 7)
			return $urandom_range(4);
		else if (p < 9)
			return $urandom_range(MB - 1, 5);
		return MB;
	endfunction

	// a word that breaks the send sequence or asks for nothing useful
	task automatic noise_word();
		case ($urandom_range(3))
			0: send_word(rand_word(KIND_HDR));
			1: send_word(rand_word(KIND_DATA));
			2: send_word(rand_word(KIND_BAD));
			default: send_word(rand_word(KIND_RX));
		endcase
	endtask

	// header and payload, with the odd stray word in between when noisy
	task automatic send_message(input int len, input bit noisy);
		send_word(header_word(len, 8'($urandom)));
		for (int i = 0; i < len; i++) begin
			if (noisy && $urandom_range(19) == 0)
				noise_word();
			send_word(data_word(8'($urandom)));
		end
	endtask

	// receive with a buffer at least as large as the oldest message most of the time, now and then one byte short
	task automatic receive_oldest();
		int         n;
		logic [7:0] lim;
		n = slot_full[rd_ptr] ? int'(slot_size[rd_ptr]) : 0;
		case ($urandom_range(9))
			0: lim = (n > 0) ? 8'(n - 1) : 8'($urandom_range(255));
			1: lim = 8'(n);
			2: lim = 8'($urandom_range(255));
			default: lim = 8'($urandom_range(255, n));
		endcase
		send_word(rx_word(1'b1, lim));
	endtask

	// random mix steered by the predicted ring state
	task automatic mixed_traffic(input int count);
		int stop_at;
		int pick;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			pick = $urandom_range(99);
			if (msg_open)
				// a noise header opened a message: fill it up
				send_word(data_word(8'($urandom)));
			else if (pick < 45 && !slot_full[wr_ptr])
				send_message(pick_len(), 1'b1);
			else if (pick < 80)
				receive_oldest();
			else if (pick < 88)
				send_word(rx_word(1'b0, 8'($urandom)));
			else
				noise_word();
		end
	endtask

	// --- tests ---

	// requests against an empty ring and words out of sequence
	task automatic test_empty_queue();
		send_word(rx_word(1'b0, 8'hFF));
		send_word(rx_word(1'b1, 8'hFF));
		send_word(data_word(8'hA5));
		send_word(rand_word(KIND_BAD));
		settle();
	endtask

	// lengths past the limit, and a message with no payload
	task automatic test_header_limits();
		send_word(header_word(MB + 1, 8'h12));
		send_word(header_word(255, 8'h34));
		send_word(header_word(0, 8'hFF));
		send_word(rx_word(1'b0, 8'h00));
		send_word(rx_word(1'b1, 8'h00));
		settle();
	endtask

	// the longest message, a header while it is open, and a buffer one byte short
	task automatic test_longest_message();
		send_word(header_word(MB, 8'h00));
		send_word(data_word(8'h00));
		send_word(data_word(8'hFF));
		send_word(header_word(1, 8'h55));
		for (int i = 2; i < MB; i++)
			send_word(data_word(8'($urandom)));
		send_word(rx_word(1'b1, 8'(MB - 1)));
		send_word(rx_word(1'b1, 8'(MB)));
		send_word(rx_word(1'b1, 8'hFF));
		settle();
	endtask

	// fill every slot, try one more, then read the ring empty
	task automatic test_ring_full();
		while (!slot_full[wr_ptr])
			send_message($urandom_range(3), 1'b0);
		send_word(header_word($urandom_range(MB), 8'($urandom)));
		send_word(data_word(8'($urandom)));
		send_word(rx_word(1'b0, 8'($urandom)));
		while (slot_full[rd_ptr])
			send_word(rx_word(1'b1, 8'hFF));
		send_word(rx_word(1'b1, 8'hFF));
		settle();
	endtask

	// receiver holds off while words keep coming, so the input backs up
	task automatic test_backpressure();
		src_idle_pct    = 0;
		sink_stall_pct  = 0;
		hold_off_cycles = HOLD_OFF_LEN;
		mixed_traffic(40);
		settle();
	endtask

	task automatic test_random_phase(input int src_pct, input int sink_pct, input int count);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		mixed_traffic(count);
		settle();
	endtask

	initial begin
		failures        = 0;
		words_sent      = 0;
		quiet_cycles    = 0;
		src_idle_pct    = 0;
		sink_stall_pct  = 0;
		hold_off_cycles = 0;
		ring_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_queue();
		test_header_limits();
		test_longest_message();
		test_ring_full();
		test_random_phase(0, 0, 80);
		test_random_phase(58, 0, 80);
		test_random_phase(0, 58, 80);
		test_backpressure();
		test_random_phase(21, 21, 80);

		if (failures == 0)
			$display("** message_ring_queue_core: PASSED **");
		else
			$display("** message_ring_queue_core: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/mrq_pkg.sv
design/mrq_ctrl.sv
design/mrq_dpath.sv
design/message_ring_queue_core.sv
design/mrq_checker.sv
tb/sv/tb.sv
